// ===== rtl/stie_pkg.sv =====
package stie_pkg;

    typedef logic [2:0]  t_cmd;
    typedef logic [1:0]  t_status;
    typedef logic [15:0] t_word;

    localparam t_cmd CMD_DECLARE = 3'd0;
    localparam t_cmd CMD_ADD     = 3'd1;
    localparam t_cmd CMD_SUB     = 3'd2;
    localparam t_cmd CMD_WRITE   = 3'd3;
    localparam t_cmd CMD_READ    = 3'd4;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_VIOL = 2'd2;

    localparam int KEY_PORT_W  = 8;
    localparam int ADDR_PORT_W = 32;

endpackage

// ===== rtl/stie_alu.sv =====
module stie_alu import stie_pkg::*; (
    input  t_cmd  i_cmd,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_value
);

    logic [16:0] w_diff;

    // One subtractor serves the floored subtract: borrow or zero means A <= B
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        unique case (i_cmd)
            CMD_DECLARE, CMD_WRITE: begin
                o_value = i_a;
            end
            CMD_ADD: begin
                o_value = i_a + i_b;
            end
            CMD_SUB: begin
                o_value = (!w_diff[16] && (w_diff[15:0] != '0)) ? w_diff[15:0] : '0;
            end
            default: begin
                o_value = '0;
            end
        endcase
    end

endmodule

// ===== rtl/stie_symtab.sv =====
module stie_symtab import stie_pkg::*; #(
    parameter int MAX_VARS  = 32,
    parameter int NAME_BITS = 8,
    parameter int IW        = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IW-1:0]        i_rd_idx,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_idx,
    input  logic [NAME_BITS-1:0] i_wr_key,
    input  t_word                i_wr_val,
    output logic [NAME_BITS-1:0] o_rd_key,
    output t_word                o_rd_val
);

    logic [NAME_BITS-1:0] r_key_mem [MAX_VARS];
    t_word                r_val_mem [MAX_VARS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_idx] <= i_wr_key;
            r_val_mem[i_wr_idx] <= i_wr_val;
        end
        if (i_rd_en) begin
            o_rd_key <= r_key_mem[i_rd_idx];
            o_rd_val <= r_val_mem[i_rd_idx];
        end
    end

endmodule

// ===== rtl/stie_wmem.sv =====
module stie_wmem import stie_pkg::*; #(
    parameter int MEM_WORDS = 65536,
    parameter int AW        = $clog2(MEM_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_addr,
    input  t_word         i_wdata,
    output t_word         o_rdata,
    output logic          o_clearing
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    t_word         r_mem [MEM_WORDS];
    logic [AW-1:0] r_clr_addr;
    logic          r_clearing;

    assign o_clearing = r_clearing;

    // Sweep every word to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// ===== rtl/symbol_table_instruction_executor_top.sv =====
// Executes one instruction per input transfer: declare, add, floored subtract,
// memory write and memory read, against a symbol table of MAX_VARS variables
// and a word memory of MEM_WORDS 16-bit words. For each instruction the
// symbol table is scanned over the variables allocated so far, one entry per
// cycle, through a single key comparator row that resolves both operands and
// the target at once; the shared ALU and memory access follow, then the table
// update. An instruction that faults on its address skips the scan and goes
// straight to its result. After reset the word memory is swept to zero, one
// word per cycle, and input is stalled until the sweep completes. A finished
// result waits in an output register, so the next instruction may be taken
// while the previous result is still stalled.
module symbol_table_instruction_executor_top import stie_pkg::*; #(
    parameter int MAX_VARS  = 32,
    parameter int MEM_WORDS = 65536,
    parameter int NAME_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_cmd                   i_cmd,
    input  logic [KEY_PORT_W-1:0]  i_dest_key,
    input  logic                   i_a_is_name,
    input  logic [KEY_PORT_W-1:0]  i_a_key,
    input  t_word                  i_a_literal,
    input  logic                   i_b_is_name,
    input  logic [KEY_PORT_W-1:0]  i_b_key,
    input  t_word                  i_b_literal,
    input  logic [ADDR_PORT_W-1:0] i_mem_address,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_status                o_status,
    output t_word                  o_result_value,
    output t_word                  o_retired_count
);

    localparam int IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int CW = $clog2(MAX_VARS + 1);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [CW-1:0]          FULL_COUNT = CW'(MAX_VARS);
    localparam logic [ADDR_PORT_W-1:0] ADDR_LIMIT = ADDR_PORT_W'(MEM_WORDS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MEM  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // control
    logic [2:0]    r_state;
    logic          r_pend;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    t_word         r_retired;
    logic          r_out_valid;

    // instruction and working payload
    t_cmd                 r_cmd;
    logic [NAME_BITS-1:0] r_dkey;
    logic [NAME_BITS-1:0] r_akey;
    logic [NAME_BITS-1:0] r_bkey;
    logic                 r_a_is_name;
    logic                 r_b_is_name;
    t_word                r_a_lit;
    t_word                r_b_lit;
    logic [AW-1:0]        r_maddr;
    logic [IW-1:0]        r_pend_idx;
    logic                 r_hit_a;
    logic                 r_hit_b;
    logic                 r_hit_d;
    t_word                r_val_a;
    t_word                r_val_b;
    logic [IW-1:0]        r_idx_d;
    t_word                r_value;
    t_status              r_status;
    t_status              r_out_status;
    t_word                r_out_value;
    t_word                r_out_retired;

    logic                 w_in_xfer;
    logic                 w_viol;
    logic                 w_out_free;
    logic                 w_scan_rd;
    logic                 w_assigns;
    logic                 w_tab_full;
    logic                 w_new_entry;
    logic                 w_sym_wr;
    logic [IW-1:0]        w_sym_wr_idx;
    logic [NAME_BITS-1:0] w_rd_key;
    t_word                w_rd_val;
    t_word                w_a;
    t_word                w_b;
    t_word                w_alu_value;
    t_word                w_mem_rdata;
    t_word                w_exec_value;
    logic                 w_clearing;
    t_word                n_retired;

    assign o_in_stall      = (r_state != S_IDLE) || w_clearing;
    assign w_in_xfer       = i_in_valid && !o_in_stall;
    assign w_viol          = ((i_cmd == CMD_WRITE) || (i_cmd == CMD_READ))
                             && (i_mem_address >= ADDR_LIMIT);
    assign w_out_free      = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_value  = r_out_value;
    assign o_retired_count = r_out_retired;

    assign w_scan_rd    = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_a          = r_a_is_name ? r_val_a : r_a_lit;
    assign w_b          = r_b_is_name ? r_val_b : r_b_lit;
    assign w_assigns    = (r_cmd == CMD_DECLARE) || (r_cmd == CMD_ADD)
                          || (r_cmd == CMD_SUB) || (r_cmd == CMD_READ);
    assign w_tab_full   = (r_count == FULL_COUNT);
    assign w_exec_value = (r_cmd == CMD_READ) ? w_mem_rdata : r_value;
    assign w_new_entry  = (r_state == S_EXEC) && w_assigns && !r_hit_d && !w_tab_full;
    assign w_sym_wr     = (r_state == S_EXEC) && w_assigns && (r_hit_d || !w_tab_full);
    assign w_sym_wr_idx = r_hit_d ? r_idx_d : r_count[IW-1:0];
    assign n_retired    = (r_status == ST_VIOL) ? r_retired : r_retired + 16'd1;

    stie_symtab #(
        .MAX_VARS  (MAX_VARS),
        .NAME_BITS (NAME_BITS),
        .IW        (IW)
    ) u_symtab (
        .i_clk    (i_clk),
        .i_rd_en  (w_scan_rd),
        .i_rd_idx (r_idx[IW-1:0]),
        .i_wr_en  (w_sym_wr),
        .i_wr_idx (w_sym_wr_idx),
        .i_wr_key (r_dkey),
        .i_wr_val (w_exec_value),
        .o_rd_key (w_rd_key),
        .o_rd_val (w_rd_val)
    );

    stie_alu u_alu (
        .i_cmd   (r_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_value (w_alu_value)
    );

    stie_wmem #(
        .MEM_WORDS (MEM_WORDS),
        .AW        (AW)
    ) u_wmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    ((r_state == S_MEM) && (r_cmd == CMD_WRITE)),
        .i_rd_en    ((r_state == S_MEM) && (r_cmd == CMD_READ)),
        .i_addr     (r_maddr),
        .i_wdata    (w_a),
        .o_rdata    (w_mem_rdata),
        .o_clearing (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_retired   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, or drop the one just transferred
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= w_viol ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= w_scan_rd;
                    if (w_scan_rd) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_MEM;
                    end
                end
                S_MEM: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_new_entry) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (w_out_free) begin
                        r_retired <= n_retired;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_cmd       <= i_cmd;
                    r_dkey      <= NAME_BITS'(i_dest_key);
                    r_akey      <= NAME_BITS'(i_a_key);
                    r_bkey      <= NAME_BITS'(i_b_key);
                    r_a_is_name <= i_a_is_name;
                    r_b_is_name <= i_b_is_name;
                    r_a_lit     <= i_a_literal;
                    r_b_lit     <= i_b_literal;
                    r_maddr     <= i_mem_address[AW-1:0];
                    r_hit_a     <= 1'b0;
                    r_hit_b     <= 1'b0;
                    r_hit_d     <= 1'b0;
                    r_val_a     <= '0;
                    r_val_b     <= '0;
                    r_status    <= w_viol ? ST_VIOL : ST_DONE;
                    r_value     <= '0;
                end
            end
            S_SCAN: begin
                r_pend_idx <= r_idx[IW-1:0];
                // compare the entry read in the previous cycle; keep first hit
                if (r_pend) begin
                    if (!r_hit_a && (w_rd_key == r_akey)) begin
                        r_hit_a <= 1'b1;
                        r_val_a <= w_rd_val;
                    end
                    if (!r_hit_b && (w_rd_key == r_bkey)) begin
                        r_hit_b <= 1'b1;
                        r_val_b <= w_rd_val;
                    end
                    if (!r_hit_d && (w_rd_key == r_dkey)) begin
                        r_hit_d <= 1'b1;
                        r_idx_d <= r_pend_idx;
                    end
                end
            end
            S_MEM: begin
                r_value <= w_alu_value;
            end
            S_EXEC: begin
                if (w_assigns && !r_hit_d && w_tab_full) begin
                    r_status <= ST_FULL;
                    r_value  <= '0;
                end else begin
                    r_status <= ST_DONE;
                    r_value  <= w_exec_value;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_status  <= r_status;
                    r_out_value   <= r_value;
                    r_out_retired <= n_retired;
                end
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

endmodule

// ===== rtl/stie_checker.sv =====
module stie_checker import stie_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_status o_status,
    input t_word   o_result_value,
    input t_word   o_retired_count
);

    t_word r_last_retired;
    logic  w_out_xfer;

    assign w_out_xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_retired <= '0;
        end else if (w_out_xfer) begin
            r_last_retired <= o_retired_count;
        end
    end

    // a faulting instruction does not retire; every other one advances by one
    a_retire_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |->
            ((o_status == ST_VIOL) && (o_retired_count == r_last_retired)) ||
            ((o_status != ST_VIOL) && (o_retired_count == r_last_retired + 16'd1)))
        else $error("retired count does not follow the transfer history");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> (o_result_value == '0))
        else $error("ignored or faulting instruction returned a nonzero value");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after a transfer");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled while memory is cleared after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_result_value)
             && $stable(o_retired_count)))
        else $error("stalled result changed");

endmodule

bind symbol_table_instruction_executor_top stie_checker u_checker (.*);
